@@ design/assert_macros.svh @@
// Assertion macros used by the checker module of the lap timer.
// No dependencies; pull in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define LST_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("lap timer check failed");

// Next-cycle implication, disabled while reset is low
`define LST_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("lap timer check failed");

`endif

@@ design/lst_pkg.sv @@
// Shared types and constants for the lap and sector split timer.
// No dependencies; used by every module of the block.
`default_nettype none

package lst_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned LAPS_W   = 16;
    localparam int unsigned SECTOR_W = 2;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    localparam logic [TIME_W-1:0] JITTER_RESET = 32'd5000;
    localparam logic [LAPS_W-1:0] LAPS_MAX     = 16'hFFFF;

    // Register indexes (byte address / 4)
    localparam logic REG_SESSION_TYPE = 1'b0;
    localparam logic REG_JITTER       = 1'b1;

    // Input mode codes
    localparam logic MODE_POSITION = 1'b0;
    localparam logic MODE_PRESS    = 1'b1;

    // Session type codes
    localparam logic SESSION_LAP   = 1'b0;
    localparam logic SESSION_ROUTE = 1'b1;

    // Sector line codes
    localparam logic [SECTOR_W-1:0] SECTOR_START = 2'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_ONE   = 2'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_TWO   = 2'd2;

    typedef struct packed {
        logic              session_type;
        logic [TIME_W-1:0] jitter_ms;
    } lst_cfg_t;

    typedef struct packed {
        logic                mode;
        logic [TIME_W-1:0]   timestamp_ms;
        logic                crossed;
        logic                fix_valid;
    } lst_item_t;

    typedef struct packed {
        logic                active;
        logic [SECTOR_W-1:0] next_sector;
        logic                awaiting_first_cross;
        logic [TIME_W-1:0]   last_cross_stamp;
        logic [TIME_W-1:0]   lap_start_stamp;
        logic [TIME_W-1:0]   sector_start_stamp;
        logic [TIME_W-1:0]   lap_time;
        logic [TIME_W-1:0]   split_one;
        logic [TIME_W-1:0]   split_two;
        logic [TIME_W-1:0]   split_three;
        logic [LAPS_W-1:0]   laps_done;
    } lst_state_t;

    typedef struct packed {
        logic                lap_done;
        logic [LAPS_W-1:0]   lap_number;
        logic [TIME_W-1:0]   lap_time_ms;
        logic [TIME_W-1:0]   sector_one_ms;
        logic [TIME_W-1:0]   sector_two_ms;
        logic [TIME_W-1:0]   sector_three_ms;
        logic                session_on;
        logic [SECTOR_W-1:0] sector_index;
    } lst_result_t;

    localparam lst_state_t STATE_RESET = '{
        active:               1'b0,
        next_sector:          SECTOR_START,
        awaiting_first_cross: 1'b1,
        last_cross_stamp:     '0,
        lap_start_stamp:      '0,
        sector_start_stamp:   '0,
        lap_time:             '0,
        split_one:            '0,
        split_two:            '0,
        split_three:          '0,
        laps_done:            '0
    };

endpackage

`default_nettype wire

@@ design/lap_sector_split_timer_core.sv @@
// Lap and three-sector split timer, top level.
// Flow: an input transfer is registered, then evaluated into the result register, from
// which its result transfers. Throughput: one item per cycle unless a waiting result stalls.
// The state update (subtract and compare) is combinational.
// Reset: async active-low rst_n clears session and lap state and sets config to defaults.
`default_nettype none

module lap_sector_split_timer_core
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         mode,
    input  wire logic [lst_pkg::TIME_W-1:0]   timestamp_ms,
    input  wire logic                         crossed,
    input  wire logic                         fix_valid,
    // result channel
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              lap_done,
    output logic      [lst_pkg::LAPS_W-1:0]   lap_number,
    output logic      [lst_pkg::TIME_W-1:0]   lap_time_ms,
    output logic      [lst_pkg::TIME_W-1:0]   sector_one_ms,
    output logic      [lst_pkg::TIME_W-1:0]   sector_two_ms,
    output logic      [lst_pkg::TIME_W-1:0]   sector_three_ms,
    output logic                              session_on,
    output logic      [lst_pkg::SECTOR_W-1:0] sector_index,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [lst_pkg::APB_AW-1:0]   paddr,
    input  wire logic [lst_pkg::APB_DW-1:0]   pwdata,
    output logic      [lst_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);

    lst_pkg::lst_cfg_t    cfg;
    lst_pkg::lst_item_t   item_reg;
    logic                 item_valid_reg;
    lst_pkg::lst_state_t  state_reg;
    lst_pkg::lst_state_t  state_next;
    lst_pkg::lst_result_t result_reg;
    lst_pkg::lst_result_t result_next;
    logic                 out_valid_reg;
    logic                 advance;

    lst_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lst_step u_step
    (
        .cfg  (cfg),
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    // Stage moves when the result register is free or being emptied
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !item_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.mode         <= mode;
            item_reg.timestamp_ms <= timestamp_ms;
            item_reg.crossed      <= crossed;
            item_reg.fix_valid    <= fix_valid;
        end
    end

    // Session state, updated once per evaluated item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lst_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid_reg;
            if (item_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance && item_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign lap_done        = result_reg.lap_done;
    assign lap_number      = result_reg.lap_number;
    assign lap_time_ms     = result_reg.lap_time_ms;
    assign sector_one_ms   = result_reg.sector_one_ms;
    assign sector_two_ms   = result_reg.sector_two_ms;
    assign sector_three_ms = result_reg.sector_three_ms;
    assign session_on      = result_reg.session_on;
    assign sector_index    = result_reg.sector_index;

endmodule

`default_nettype wire

@@ design/lst_cfg_regs.sv @@
// APB-style configuration registers: session type and jitter window.
// Depends on lst_pkg.
`default_nettype none

module lst_cfg_regs
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lst_pkg::APB_AW-1:0] paddr,
    input  wire logic [lst_pkg::APB_DW-1:0] pwdata,
    output logic      [lst_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output lst_pkg::lst_cfg_t               cfg
);

    logic                       session_type_reg;
    logic [lst_pkg::TIME_W-1:0] jitter_reg;
    logic                       wr_en;
    logic                       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    // Register writes on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_type_reg <= 1'b0;
            jitter_reg       <= lst_pkg::JITTER_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                lst_pkg::REG_SESSION_TYPE: session_type_reg <= pwdata[0];
                lst_pkg::REG_JITTER:       jitter_reg       <= pwdata;
                default:                   jitter_reg       <= jitter_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_sel)
            lst_pkg::REG_SESSION_TYPE: prdata = {31'd0, session_type_reg};
            lst_pkg::REG_JITTER:       prdata = jitter_reg;
            default:                   prdata = '0;
        endcase
    end

    assign cfg.session_type = session_type_reg;
    assign cfg.jitter_ms    = jitter_reg;

endmodule

`default_nettype wire

@@ design/lst_step.sv @@
// Next-state and result logic for one input item of the split timer.
// Depends on lst_pkg; purely combinational.
`default_nettype none

module lst_step
(
    input  wire lst_pkg::lst_cfg_t   cfg,
    input  wire lst_pkg::lst_item_t  item,
    input  wire lst_pkg::lst_state_t cur,
    output lst_pkg::lst_state_t      nxt,
    output lst_pkg::lst_result_t     res
);

    logic [lst_pkg::TIME_W-1:0] since_cross;
    logic [lst_pkg::TIME_W-1:0] since_lap;
    logic [lst_pkg::TIME_W-1:0] since_sector;
    logic                       cross_ok;
    logic                       lap_done;

    assign since_cross  = item.timestamp_ms - cur.last_cross_stamp;
    assign since_lap    = item.timestamp_ms - cur.lap_start_stamp;
    assign since_sector = item.timestamp_ms - cur.sector_start_stamp;

    // Crossing counts only in an active lap session and outside the jitter window
    assign cross_ok = (item.mode == lst_pkg::MODE_POSITION) && cur.active
                      && (cfg.session_type == lst_pkg::SESSION_LAP)
                      && item.crossed && (since_cross > cfg.jitter_ms);

    always_comb
    begin
        nxt      = cur;
        lap_done = 1'b0;
        if (item.mode == lst_pkg::MODE_PRESS)
        begin
            // start (fix needed) or stop
            if (!cur.active && item.fix_valid)
            begin
                if (cfg.session_type == lst_pkg::SESSION_LAP)
                begin
                    nxt = lst_pkg::STATE_RESET;
                end
                nxt.active = 1'b1;
            end
            else if (cur.active)
            begin
                nxt.active = 1'b0;
            end
        end
        else if (cross_ok)
        begin
            nxt.last_cross_stamp = item.timestamp_ms;
            nxt.sector_start_stamp = item.timestamp_ms;
            case (cur.next_sector)
                lst_pkg::SECTOR_START:
                begin
                    if (cur.awaiting_first_cross)
                    begin
                        nxt.awaiting_first_cross = 1'b0;
                    end
                    else
                    begin
                        nxt.lap_time    = since_lap;
                        nxt.split_three = since_sector;
                        if (cur.laps_done != lst_pkg::LAPS_MAX)
                        begin
                            nxt.laps_done = cur.laps_done + 1'b1;
                        end
                        lap_done = 1'b1;
                    end
                    nxt.lap_start_stamp = item.timestamp_ms;
                    nxt.next_sector     = lst_pkg::SECTOR_ONE;
                end
                lst_pkg::SECTOR_ONE:
                begin
                    nxt.split_one   = since_sector;
                    nxt.next_sector = lst_pkg::SECTOR_TWO;
                end
                default:
                begin
                    nxt.split_two   = since_sector;
                    nxt.next_sector = lst_pkg::SECTOR_START;
                end
            endcase
        end
    end

    // Result reflects the updated state
    always_comb
    begin
        res.lap_done        = lap_done;
        res.lap_number      = nxt.laps_done;
        res.lap_time_ms     = nxt.lap_time;
        res.sector_one_ms   = nxt.split_one;
        res.sector_two_ms   = nxt.split_two;
        res.sector_three_ms = nxt.split_three;
        res.session_on      = nxt.active;
        res.sector_index    = nxt.next_sector;
    end

endmodule

`default_nettype wire

@@ design/lst_checker.sv @@
// Port-level checks for the split timer top level, plus the bind that attaches them.
// Depends on lst_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lst_checker
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         out_valid,
    input wire logic                         out_ready,
    input wire logic                         lap_done,
    input wire logic [lst_pkg::LAPS_W-1:0]   lap_number,
    input wire logic                         session_on,
    input wire logic [lst_pkg::SECTOR_W-1:0] sector_index
);

    // A closed lap leaves the session running and aims at the first split line
    `LST_ASSERT_IMPLY(a_lap_next_sector, clk, rst_n, out_valid && lap_done, session_on && (sector_index == lst_pkg::SECTOR_ONE))

    // A closed lap is always counted
    `LST_ASSERT_IMPLY(a_lap_counted, clk, rst_n, out_valid && lap_done, lap_number != '0)

    // Sector index never takes the unused code
    `LST_ASSERT_IMPLY(a_sector_range, clk, rst_n, out_valid, sector_index != 2'd3)

    // A stalled result holds
    `LST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(lap_number) && $stable(lap_done))

endmodule

bind lap_sector_split_timer_core lst_checker u_lst_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .lap_done     (lap_done),
    .lap_number   (lap_number),
    .session_on   (session_on),
    .sector_index (sector_index)
);

`default_nettype wire

@@ dv/tb_lap_sector_split_timer_core.sv @@
// Testbench for the lap and three-sector split timer: directed and random transfers,
// a short run of back-to-back laps, checked against an in-bench lap/sector predictor.
// Depends on lst_pkg and lap_sector_split_timer_core only.
`default_nettype none

module tb_lap_sector_split_timer_core;
    import lst_pkg::*;

    // Predictor of session and lap/sector state, plus the queue of expected results
    class lap_scoreboard;
        logic              session_kind;
        logic [TIME_W-1:0] jitter_ms;
        lst_state_t        state;
        lst_result_t       expected_results[$];
        int                errors;
        int                checked;
        int                transfers;
        int                laps_closed;

        function new();
            session_kind = SESSION_LAP;
            jitter_ms    = JITTER_RESET;
            state        = STATE_RESET;
            errors       = 0;
            checked      = 0;
            transfers    = 0;
            laps_closed  = 0;
        endfunction

        function void set_reg(logic idx, logic [APB_DW-1:0] value);
            if (idx == REG_SESSION_TYPE)
                session_kind = value[0];
            else
                jitter_ms = value;
        endfunction

        function logic [APB_DW-1:0] reg_value(logic idx);
            if (idx == REG_SESSION_TYPE)
                return {{(APB_DW-1){1'b0}}, session_kind};
            return jitter_ms;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Apply one accepted input to the lap state and queue the result it yields
        function void predict_lap_result(lst_item_t it);
            lst_result_t       res;
            logic [TIME_W-1:0] gap;
            logic              closed;
            closed = 1'b0;
            transfers++;
            if (it.mode == MODE_PRESS) begin
                if (!state.active && it.fix_valid) begin
                    // starting in lap mode wipes all lap data
                    if (session_kind == SESSION_LAP)
                        state = STATE_RESET;
                    state.active = 1'b1;
                end
                else if (state.active) begin
                    state.active = 1'b0;
                end
            end
            else if (state.active && session_kind == SESSION_LAP && it.crossed) begin
                gap = it.timestamp_ms - state.last_cross_stamp;
                if (gap > jitter_ms) begin
                    state.last_cross_stamp = it.timestamp_ms;
                    case (state.next_sector)
                        SECTOR_START:
                        begin
                            if (state.awaiting_first_cross) begin
                                state.awaiting_first_cross = 1'b0;
                            end
                            else begin
                                state.lap_time    = it.timestamp_ms - state.lap_start_stamp;
                                state.split_three = it.timestamp_ms - state.sector_start_stamp;
                                if (state.laps_done != LAPS_MAX)
                                    state.laps_done++;
                                closed = 1'b1;
                            end
                            state.lap_start_stamp    = it.timestamp_ms;
                            state.sector_start_stamp = it.timestamp_ms;
                            state.next_sector        = SECTOR_ONE;
                        end
                        SECTOR_ONE:
                        begin
                            state.split_one          = it.timestamp_ms - state.sector_start_stamp;
                            state.sector_start_stamp = it.timestamp_ms;
                            state.next_sector        = SECTOR_TWO;
                        end
                        default:
                        begin
                            state.split_two          = it.timestamp_ms - state.sector_start_stamp;
                            state.sector_start_stamp = it.timestamp_ms;
                            state.next_sector        = SECTOR_START;
                        end
                    endcase
                end
            end
            if (closed)
                laps_closed++;
            res.lap_done        = closed;
            res.lap_number      = state.laps_done;
            res.lap_time_ms     = state.lap_time;
            res.sector_one_ms   = state.split_one;
            res.sector_two_ms   = state.split_two;
            res.sector_three_ms = state.split_three;
            res.session_on      = state.active;
            res.sector_index    = state.next_sector;
            expected_results.insert(expected_results.size(), res);
        endfunction

        // Only the first few mismatches are printed to keep the log short
        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= 20)
                    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_lap_result(lst_result_t got);
            lst_result_t want;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 20)
                    $display("%0t: unexpected result, expected none, got lap %0d sector %0d",
                             $time, got.lap_number, got.sector_index);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            compare_field("lap_done", want.lap_done, got.lap_done);
            compare_field("lap_number", want.lap_number, got.lap_number);
            compare_field("lap_time_ms", want.lap_time_ms, got.lap_time_ms);
            compare_field("sector_one_ms", want.sector_one_ms, got.sector_one_ms);
            compare_field("sector_two_ms", want.sector_two_ms, got.sector_two_ms);
            compare_field("sector_three_ms", want.sector_three_ms, got.sector_three_ms);
            compare_field("session_on", want.session_on, got.session_on);
            compare_field("sector_index", want.sector_index, got.sector_index);
        endfunction
    endclass

    // Clock, reset and block ports
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                mode = MODE_POSITION;
    logic [TIME_W-1:0]   timestamp_ms = '0;
    logic                crossed = 1'b0;
    logic                fix_valid = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                lap_done;
    logic [LAPS_W-1:0]   lap_number;
    logic [TIME_W-1:0]   lap_time_ms;
    logic [TIME_W-1:0]   sector_one_ms;
    logic [TIME_W-1:0]   sector_two_ms;
    logic [TIME_W-1:0]   sector_three_ms;
    logic                session_on;
    logic [SECTOR_W-1:0] sector_index;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    lst_result_t         result_seen;
    lap_scoreboard       sb = new();
    int                  idle_pct = 0;
    int                  stall_pct = 0;
    logic [TIME_W-1:0]   clock_ms = '0;

    always #1 clk = ~clk;

    lap_sector_split_timer_core dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .timestamp_ms    (timestamp_ms),
        .crossed         (crossed),
        .fix_valid       (fix_valid),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .lap_done        (lap_done),
        .lap_number      (lap_number),
        .lap_time_ms     (lap_time_ms),
        .sector_one_ms   (sector_one_ms),
        .sector_two_ms   (sector_two_ms),
        .sector_three_ms (sector_three_ms),
        .session_on      (session_on),
        .sector_index    (sector_index),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    assign result_seen = {lap_done, lap_number, lap_time_ms, sector_one_ms, sector_two_ms,
                          sector_three_ms, session_on, sector_index};

    // Result side: check each transfer, then pick the next ready at random
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_lap_result(result_seen);
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Input side: optional idle cycles, then hold the item until it transfers
    task automatic send_item(input lst_item_t it);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= it.mode;
        timestamp_ms <= it.timestamp_ms;
        crossed      <= it.crossed;
        fix_valid    <= it.fix_valid;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.predict_lap_result(it);
    endtask

    task automatic put_item(logic m, logic [TIME_W-1:0] ts, logic cr, logic fv);
        lst_item_t it;
        it.mode         = m;
        it.timestamp_ms = ts;
        it.crossed      = cr;
        it.fix_valid    = fv;
        send_item(it);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write with the block idle, then read it back
    task automatic cfg_write(logic idx, logic [APB_DW-1:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.compare_field("prdata", sb.reg_value(idx), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly well-formed driving with gaps around the jitter window, some presses and noise
    function automatic lst_item_t random_item();
        lst_item_t      it;
        longint signed  step;
        longint signed  jit;
        int             pick;
        jit = sb.jitter_ms;
        it.fix_valid = ($urandom_range(9) != 0);
        it.crossed   = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < (sb.state.active ? 2 : 25)) begin
            it.mode = MODE_PRESS;
            clock_ms += $urandom_range(500);
            it.timestamp_ms = clock_ms;
        end
        else if (pick < (sb.state.active ? 6 : 29)) begin
            it.mode         = MODE_POSITION;
            it.timestamp_ms = $urandom();
        end
        else begin
            it.mode    = MODE_POSITION;
            it.crossed = ($urandom_range(99) < 70);
            pick = $urandom_range(9);
            if (pick < 3)
                step = $urandom_range(32'(jit >> 1));
            else if (pick < 5)
                step = jit - 1 + $urandom_range(3);
            else
                step = jit + 1 + $urandom_range(3000);
            if (step < 0)
                step = 0;
            clock_ms += 32'(step);
            it.timestamp_ms = clock_ms;
        end
        return it;
    endfunction

    task automatic run_phase(logic kind, logic [TIME_W-1:0] jit, int idle, int stall,
                             int count, logic [TIME_W-1:0] clock_start);
        cfg_write(REG_SESSION_TYPE, kind);
        cfg_write(REG_JITTER, jit);
        idle_pct  = idle;
        stall_pct <= stall;
        clock_ms  = clock_start;
        repeat (count) begin
            // now and then hold off until the block has emptied
            if ($urandom_range(199) == 0)
                drain();
            send_item(random_item());
        end
    endtask

    // Back-to-back crossings with no jitter window, closing a lap every third transfer
    task automatic lap_counter_run();
        cfg_write(REG_SESSION_TYPE, SESSION_LAP);
        cfg_write(REG_JITTER, '0);
        idle_pct  = 0;
        stall_pct <= 0;
        if (sb.state.active)
            put_item(MODE_PRESS, clock_ms, 1'b0, 1'b1);
        put_item(MODE_PRESS, clock_ms, 1'b0, 1'b1);
        repeat (31) begin
            clock_ms += 1 + $urandom_range(3);
            put_item(MODE_POSITION, clock_ms, 1'b1, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: session control, jitter edge, sectors, mode switches, wrap
        cfg_write(REG_SESSION_TYPE, 32'hFFFF_FFFE);
        cfg_write(REG_JITTER, JITTER_RESET);
        put_item(MODE_POSITION, 32'hFFFF_FFFF, 1'b1, 1'b1);
        put_item(MODE_PRESS, 32'd0, 1'b1, 1'b0);
        put_item(MODE_PRESS, 32'd0, 1'b1, 1'b1);
        put_item(MODE_POSITION, 32'd5000, 1'b1, 1'b1);
        put_item(MODE_POSITION, 32'd5001, 1'b1, 1'b0);
        put_item(MODE_POSITION, 32'd20000, 1'b0, 1'b1);
        put_item(MODE_POSITION, 32'd10001, 1'b1, 1'b1);
        put_item(MODE_POSITION, 32'd10002, 1'b1, 1'b1);
        put_item(MODE_POSITION, 32'd16000, 1'b1, 1'b1);
        put_item(MODE_POSITION, 32'd30000, 1'b1, 1'b1);
        put_item(MODE_POSITION, 32'd36000, 1'b1, 1'b1);
        put_item(MODE_PRESS, 32'd40000, 1'b0, 1'b0);
        put_item(MODE_POSITION, 32'd50000, 1'b1, 1'b1);
        cfg_write(REG_SESSION_TYPE, SESSION_ROUTE);
        put_item(MODE_PRESS, 32'd55000, 1'b0, 1'b1);
        put_item(MODE_POSITION, 32'd70000, 1'b1, 1'b1);
        // back to lap mode mid-session: kept lap data picks up where it was
        cfg_write(REG_SESSION_TYPE, SESSION_LAP);
        put_item(MODE_POSITION, 32'd70000, 1'b1, 1'b1);
        cfg_write(REG_SESSION_TYPE, SESSION_ROUTE);
        put_item(MODE_PRESS, 32'd80000, 1'b1, 1'b1);
        cfg_write(REG_SESSION_TYPE, SESSION_LAP);
        cfg_write(REG_JITTER, '0);
        put_item(MODE_PRESS, 32'd0, 1'b0, 1'b1);
        put_item(MODE_POSITION, 32'd0, 1'b1, 1'b1);
        put_item(MODE_POSITION, 32'hFFFF_FFFF, 1'b1, 1'b1);
        put_item(MODE_POSITION, 32'd0, 1'b1, 1'b1);
        put_item(MODE_POSITION, 32'd0, 1'b1, 1'b1);

        // Random phases over settings and flow-control patterns
        run_phase(SESSION_LAP, JITTER_RESET, 0, 0, 400, 32'd100000);
        run_phase(SESSION_LAP, $urandom_range(2000, 1), 79, 0, 400, $urandom());
        run_phase(SESSION_LAP, '0, 0, 79, 400, 32'hFFFF_F000);
        run_phase(SESSION_ROUTE, $urandom(), 11, 11, 120, $urandom());
        run_phase(SESSION_LAP, 32'hFFFF_FFFF, 11, 11, 100, $urandom());
        run_phase(SESSION_LAP, $urandom_range(4000), 11, 11, 300, $urandom());

        lap_counter_run();

        drain();
        repeat (10) @(posedge clk);
        $display("Checked %0d results from %0d transfers; %0d laps closed, counter ended at %0d.",
                 sb.checked, sb.transfers, sb.laps_closed, sb.state.laps_done);
        $display("Covered both session types, jitter from 0 to all ones, and time wrap.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #3000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
